// ===== rtl/fresr_pkg.sv =====
// ----------------------------------------------------------------------------
// fresr_pkg
// Widths and constants shared by the Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package fresr_pkg;

    localparam int SQ_RAD_W  = 58;   // radicand, Q.56 padded to even width
    localparam int SQ_ROOT_W = 29;   // root, Q.28
    localparam int SQ_REM_W  = 31;   // partial remainder

    localparam int IDX_W     = 16;   // refractive index, Q4.12
    localparam int COS_W     = 29;   // cosines and sines, Q.28
    localparam int SINT_W    = 28;   // transmitted sine below one
    localparam int PROD_W    = 45;   // index times Q.28 value
    localparam int RDEN_W    = 46;   // ratio numerator and denominator
    localparam int RQ_W      = 17;   // ratio quotient, Q.16 up to 1.0
    localparam int TQ_W      = 28;   // transmitted sine quotient bits

    localparam logic [SQ_RAD_W-1:0] ONE_Q56 = SQ_RAD_W'(1) << 56;
    localparam logic [COS_W-1:0]    ONE_Q28 = COS_W'(1) << 28;
    localparam logic [RQ_W-1:0]     ONE_Q16 = RQ_W'(1) << 16;
    localparam logic [15:0]         REFL_ONE = 16'h8000;

endpackage

// ===== rtl/fresr_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// fresr_sqrt_cell
// One step of a digit-by-digit square root: retires one root bit per cycle while i_en is high.
// ----------------------------------------------------------------------------
module fresr_sqrt_cell #(
    parameter int SW = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [fresr_pkg::SQ_REM_W-1:0]  i_rem,
    input  logic [fresr_pkg::SQ_ROOT_W-1:0] i_root,
    input  logic [fresr_pkg::SQ_RAD_W-1:0]  i_rad,
    input  logic [SW-1:0]                  i_side,
    output logic                           o_valid,
    output logic [fresr_pkg::SQ_REM_W-1:0]  o_rem,
    output logic [fresr_pkg::SQ_ROOT_W-1:0] o_root,
    output logic [fresr_pkg::SQ_RAD_W-1:0]  o_rad,
    output logic [SW-1:0]                  o_side
);
    import fresr_pkg::*;

    localparam int TW = SQ_REM_W + 2;

    logic [TW-1:0]        t;
    logic [TW-1:0]        trial;
    logic                 ge;
    logic [SQ_REM_W-1:0]  n_rem;
    logic [SQ_ROOT_W-1:0] n_root;

    logic                 r_valid;
    logic [SQ_REM_W-1:0]  r_rem;
    logic [SQ_ROOT_W-1:0] r_root;
    logic [SQ_RAD_W-1:0]  r_rad;
    logic [SW-1:0]        r_side;

    always_comb begin
        t      = {i_rem, i_rad[SQ_RAD_W-1 -: 2]};
        trial  = {2'b00, i_root, 2'b01};
        ge     = (t >= trial);
        n_rem  = ge ? SQ_REM_W'(t - trial) : SQ_REM_W'(t);
        n_root = {i_root[SQ_ROOT_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= {i_rad[SQ_RAD_W-3:0], 2'b00};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_side  = r_side;

endmodule

// ===== rtl/fresr_sqrt.sv =====
// ----------------------------------------------------------------------------
// fresr_sqrt
// Row of square root cells, floor root of a Q.56 value, one bit per cell.
// ----------------------------------------------------------------------------
module fresr_sqrt #(
    parameter int SW = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [fresr_pkg::SQ_RAD_W-1:0]  i_rad,
    input  logic [SW-1:0]                  i_side,
    output logic                           o_valid,
    output logic [fresr_pkg::SQ_ROOT_W-1:0] o_root,
    output logic [SW-1:0]                  o_side
);
    import fresr_pkg::*;

    localparam int N = SQ_ROOT_W;

    logic                 c_valid [N+1];
    logic [SQ_REM_W-1:0]  c_rem   [N+1];
    logic [SQ_ROOT_W-1:0] c_root  [N+1];
    logic [SQ_RAD_W-1:0]  c_rad   [N+1];
    logic [SW-1:0]        c_side  [N+1];

    assign c_valid[0] = i_valid;
    assign c_rem[0]   = '0;
    assign c_root[0]  = '0;
    assign c_rad[0]   = i_rad;
    assign c_side[0]  = i_side;

    for (genvar g = 0; g < N; g++) begin : g_cell
        fresr_sqrt_cell #(.SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (c_valid[g]),
            .i_rem   (c_rem[g]),
            .i_root  (c_root[g]),
            .i_rad   (c_rad[g]),
            .i_side  (c_side[g]),
            .o_valid (c_valid[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_root  (c_root[g+1]),
            .o_rad   (c_rad[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    assign o_valid = c_valid[N];
    assign o_root  = c_root[N];
    assign o_side  = c_side[N];

endmodule

// ===== rtl/fresr_div_cell.sv =====
// ----------------------------------------------------------------------------
// fresr_div_cell
// One restoring division step: retires one quotient bit per cycle while i_en is high.
// ----------------------------------------------------------------------------
module fresr_div_cell #(
    parameter int DW = 16,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    input  logic [QW-1:0] i_low,
    input  logic [QW-1:0] i_q,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_rem,
    output logic [DW-1:0] o_den,
    output logic [QW-1:0] o_low,
    output logic [QW-1:0] o_q,
    output logic [SW-1:0] o_side
);
    logic [DW:0]   t;
    logic          ge;
    logic [DW-1:0] n_rem;

    logic          r_valid;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_low;
    logic [QW-1:0] r_q;
    logic [SW-1:0] r_side;

    always_comb begin
        t     = {i_rem, i_low[QW-1]};
        ge    = (t >= {1'b0, i_den});
        n_rem = ge ? DW'(t - {1'b0, i_den}) : DW'(t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_low  <= {i_low[QW-2:0], 1'b0};
            r_q    <= {i_q[QW-2:0], ge};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_low   = r_low;
    assign o_q     = r_q;
    assign o_side  = r_side;

endmodule

// ===== rtl/fresr_div.sv =====
// ----------------------------------------------------------------------------
// fresr_div
// Row of division cells; initial remainder must be below the divisor.
// ----------------------------------------------------------------------------
module fresr_div #(
    parameter int DW = 16,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    input  logic [QW-1:0] i_low,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_q,
    output logic [SW-1:0] o_side
);
    logic          c_valid [QW+1];
    logic [DW-1:0] c_rem   [QW+1];
    logic [DW-1:0] c_den   [QW+1];
    logic [QW-1:0] c_low   [QW+1];
    logic [QW-1:0] c_q     [QW+1];
    logic [SW-1:0] c_side  [QW+1];

    assign c_valid[0] = i_valid;
    assign c_rem[0]   = i_rem;
    assign c_den[0]   = i_den;
    assign c_low[0]   = i_low;
    assign c_q[0]     = '0;
    assign c_side[0]  = i_side;

    for (genvar g = 0; g < QW; g++) begin : g_cell
        fresr_div_cell #(.DW(DW), .QW(QW), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (c_valid[g]),
            .i_rem   (c_rem[g]),
            .i_den   (c_den[g]),
            .i_low   (c_low[g]),
            .i_q     (c_q[g]),
            .i_side  (c_side[g]),
            .o_valid (c_valid[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_den   (c_den[g+1]),
            .o_low   (c_low[g+1]),
            .o_q     (c_q[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    assign o_valid = c_valid[QW];
    assign o_q     = c_q[QW];
    assign o_side  = c_side[QW];

endmodule

// ===== rtl/fresnel_reflectance_top.sv =====
// ----------------------------------------------------------------------------
// fresnel_reflectance_top
// Unpolarized Fresnel reflectance of a dielectric surface, fully pipelined.
// ----------------------------------------------------------------------------
// usage:
//   input request: incident direction and normal (Q1.14) plus the material
//   index (Q4.12), taken when i_valid is high and o_stall is low
//   output request: reflectance (Q1.15) and the total internal reflection
//   flag, taken when o_valid is high and i_stall is low
//   one request per cycle in, one result per cycle out, while nothing stalls
//   the pipeline holds two 29-cell square root rows, a 28-cell divider row
//   for the transmitted sine and two parallel 17-cell divider rows for the s
//   and p coefficients, plus the multiply stages between them
//   the whole pipeline moves as one; a stall of the receiver while a result
//   waits moves that result into a skid register, which raises o_stall from
//   the next cycle and freezes every stage until the receiver takes it
//   reset clears all valid bits; no clearing pass, requests taken at once
// ----------------------------------------------------------------------------
module fresnel_reflectance_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_incident_x,
    input  logic signed [15:0] i_incident_y,
    input  logic signed [15:0] i_incident_z,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic        [15:0] i_refractive_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic        [15:0] o_reflectance,
    output logic               o_total_internal
);
    import fresr_pkg::*;

    localparam int SIDE1_W = 1 + IDX_W + COS_W;
    localparam int SIDE2_W = 2 + IDX_W + COS_W + SINT_W;
    localparam int SIDE3_W = 1 + IDX_W + COS_W;

    logic en;

    // stage 0: products
    logic                r_v0;
    logic signed [31:0]  r_px, r_py, r_pz;
    logic [IDX_W-1:0]    r_n0;

    // stage 1: clamped cosine
    logic                r_v1;
    logic                r_pos1;
    logic [COS_W-1:0]    r_cosa1;
    logic [IDX_W-1:0]    r_n1;
    logic signed [33:0]  dot;
    logic                n_pos1;
    logic [COS_W-1:0]    n_cosa1;

    // stage 2: sine squared
    logic                r_v2;
    logic [SQ_RAD_W-1:0] r_rad2;
    logic [SIDE1_W-1:0]  r_side2;
    logic [SQ_RAD_W-1:0] cos_sq;

    logic                 sq1_v;
    logic [SQ_ROOT_W-1:0] sq1_root;
    logic [SIDE1_W-1:0]   sq1_side;
    logic                 sq1_pos;
    logic [IDX_W-1:0]     sq1_n;
    logic [COS_W-1:0]     sq1_cosa;

    // stage 3: snell
    logic                 r_v3;
    logic [SQ_ROOT_W-1:0] r_sinv3;
    logic [IDX_W-1:0]     r_n3;
    logic [SIDE2_W-1:0]   r_side3;
    logic [PROD_W-1:0]    snell_p;
    logic                 n_tir3;

    logic                 d1_v;
    logic [TQ_W-1:0]      d1_q;
    logic [SIDE2_W-1:0]   d1_side;
    logic                 d1_pos, d1_tir;
    logic [IDX_W-1:0]     d1_n;
    logic [COS_W-1:0]     d1_cosa;
    logic [SINT_W-1:0]    d1_sl;

    // stage 4: transmitted cosine squared
    logic                 r_v4;
    logic [SQ_RAD_W-1:0]  r_rad4;
    logic [SIDE3_W-1:0]   r_side4;
    logic [SINT_W-1:0]    sint;
    logic [2*SINT_W-1:0]  sint_sq;

    logic                 sq2_v;
    logic [SQ_ROOT_W-1:0] sq2_root;
    logic [SIDE3_W-1:0]   sq2_side;

    // stage 5: index products
    logic                 r_v5;
    logic                 r_tir5;
    logic [PROD_W-1:0]    r_a5, r_b5;
    logic [COS_W-1:0]     r_cosa5, r_cost5;
    logic [IDX_W-1:0]     s5_n;
    logic [COS_W-1:0]     s5_cosa;

    // stage 6: ratio operands
    logic                 r_v6;
    logic [1:0]           r_side6a;
    logic                 r_side6b;
    logic [RDEN_W-1:0]    r_rem6a, r_rem6b, r_den6a, r_den6b;
    logic [RQ_W-1:0]      r_low6a, r_low6b;
    logic [RDEN_W-1:0]    va, vb, vc, vd, x1, x2, d1s, d2s;
    logic [61:0]          num1, num2;

    logic                 ra_v, rb_v;
    logic [RQ_W-1:0]      ra_q, rb_q;
    logic [1:0]           ra_side;
    logic                 rb_side;

    // stage 7: squares
    logic                 r_v7;
    logic                 r_tir7;
    logic [2*RQ_W-1:0]    r_rs2, r_rp2;
    logic [RQ_W-1:0]      rs, rp;

    // stage 8: output
    logic                 r_v8;
    logic [15:0]          r_refl;
    logic                 r_tir8;
    logic [2*RQ_W:0]      ksum;
    logic [RQ_W-1:0]      kr;

    // skid register
    logic                 r_sv;
    logic [15:0]          r_srefl;
    logic                 r_stir;

    assign en      = !r_sv;
    assign o_stall = r_sv;

    // stage 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px <= i_incident_x * i_normal_x;
            r_py <= i_incident_y * i_normal_y;
            r_pz <= i_incident_z * i_normal_z;
            r_n0 <= (i_refractive_index == '0) ? IDX_W'(1) : i_refractive_index;
        end
    end

    // stage 1
    always_comb begin
        dot = 34'(r_px) + 34'(r_py) + 34'(r_pz);
        if (dot > 34'sd268435456) begin
            n_pos1  = 1'b1;
            n_cosa1 = ONE_Q28;
        end else if (dot < -34'sd268435456) begin
            n_pos1  = 1'b0;
            n_cosa1 = ONE_Q28;
        end else begin
            n_pos1  = (dot > 34'sd0);
            n_cosa1 = dot[33] ? COS_W'(-dot) : COS_W'(dot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos1  <= n_pos1;
            r_cosa1 <= n_cosa1;
            r_n1    <= r_n0;
        end
    end

    // stage 2
    assign cos_sq = SQ_RAD_W'(r_cosa1) * SQ_RAD_W'(r_cosa1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad2  <= ONE_Q56 - cos_sq;
            r_side2 <= {r_pos1, r_n1, r_cosa1};
        end
    end

    fresr_sqrt #(.SW(SIDE1_W)) u_sqrt_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v2),
        .i_rad   (r_rad2),
        .i_side  (r_side2),
        .o_valid (sq1_v),
        .o_root  (sq1_root),
        .o_side  (sq1_side)
    );

    assign {sq1_pos, sq1_n, sq1_cosa} = sq1_side;

    // stage 3
    always_comb begin
        snell_p = PROD_W'(sq1_n) * PROD_W'(sq1_root);
        if (sq1_pos) begin
            n_tir3 = (snell_p >= (PROD_W'(1) << 40));
        end else begin
            n_tir3 = ({3'b000, sq1_root} >= {sq1_n, 16'h0000});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= sq1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sinv3 <= sq1_root;
            r_n3    <= sq1_n;
            r_side3 <= {sq1_pos, n_tir3, sq1_n, sq1_cosa, snell_p[39:12]};
        end
    end

    fresr_div #(.DW(IDX_W), .QW(TQ_W), .SW(SIDE2_W)) u_div_sint (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v3),
        .i_rem   ({3'b000, r_sinv3[28:16]}),
        .i_den   (r_n3),
        .i_low   ({r_sinv3[15:0], 12'h000}),
        .i_side  (r_side3),
        .o_valid (d1_v),
        .o_q     (d1_q),
        .o_side  (d1_side)
    );

    assign {d1_pos, d1_tir, d1_n, d1_cosa, d1_sl} = d1_side;

    // stage 4
    assign sint    = d1_pos ? d1_sl : d1_q;
    assign sint_sq = sint * sint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad4  <= ONE_Q56 - SQ_RAD_W'(sint_sq);
            r_side4 <= {d1_tir, d1_n, d1_cosa};
        end
    end

    fresr_sqrt #(.SW(SIDE3_W)) u_sqrt_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v4),
        .i_rad   (r_rad4),
        .i_side  (r_side4),
        .o_valid (sq2_v),
        .o_root  (sq2_root),
        .o_side  (sq2_side)
    );

    // stage 5
    assign s5_n    = sq2_side[IDX_W+COS_W-1 -: IDX_W];
    assign s5_cosa = sq2_side[COS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5 <= sq2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tir5  <= sq2_side[SIDE3_W-1];
            r_a5    <= PROD_W'(s5_n) * PROD_W'(s5_cosa);
            r_b5    <= PROD_W'(s5_n) * PROD_W'(sq2_root);
            r_cosa5 <= s5_cosa;
            r_cost5 <= sq2_root;
        end
    end

    // stage 6: both coefficients are |x| / d with x and d from these sums
    always_comb begin
        va   = RDEN_W'(r_a5);
        vb   = RDEN_W'(r_b5);
        vc   = RDEN_W'({r_cosa5, 12'h000});
        vd   = RDEN_W'({r_cost5, 12'h000});
        x1   = (vc >= vb) ? (vc - vb) : (vb - vc);
        d1s  = vc + vb;
        x2   = (va >= vd) ? (va - vd) : (vd - va);
        d2s  = va + vd;
        num1 = {x1, 16'h0000} + 62'(d1s >> 1);
        num2 = {x2, 16'h0000} + 62'(d2s >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem6a  <= RDEN_W'(num1[61:RQ_W]);
            r_rem6b  <= RDEN_W'(num2[61:RQ_W]);
            r_low6a  <= num1[RQ_W-1:0];
            r_low6b  <= num2[RQ_W-1:0];
            r_den6a  <= d1s;
            r_den6b  <= d2s;
            r_side6a <= {r_tir5, (d1s == '0)};
            r_side6b <= (d2s == '0);
        end
    end

    fresr_div #(.DW(RDEN_W), .QW(RQ_W), .SW(2)) u_div_rs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v6),
        .i_rem   (r_rem6a),
        .i_den   (r_den6a),
        .i_low   (r_low6a),
        .i_side  (r_side6a),
        .o_valid (ra_v),
        .o_q     (ra_q),
        .o_side  (ra_side)
    );

    fresr_div #(.DW(RDEN_W), .QW(RQ_W), .SW(1)) u_div_rp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v6),
        .i_rem   (r_rem6b),
        .i_den   (r_den6b),
        .i_low   (r_low6b),
        .i_side  (r_side6b),
        .o_valid (rb_v),
        .o_q     (rb_q),
        .o_side  (rb_side)
    );

    // stage 7
    assign rs = (ra_side[0] || ra_q > ONE_Q16) ? ONE_Q16 : ra_q;
    assign rp = (rb_side || rb_q > ONE_Q16) ? ONE_Q16 : rb_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else if (en) begin
            r_v7 <= ra_v && rb_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tir7 <= ra_side[1];
            r_rs2  <= (2*RQ_W)'(rs) * (2*RQ_W)'(rs);
            r_rp2  <= (2*RQ_W)'(rp) * (2*RQ_W)'(rp);
        end
    end

    // stage 8
    always_comb begin
        ksum = (2*RQ_W+1)'(r_rs2) + (2*RQ_W+1)'(r_rp2) + ((2*RQ_W+1)'(1) << 17);
        kr   = ksum[RQ_W+17:18];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else if (en) begin
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tir8 <= r_tir7;
            if (r_tir7 || kr > RQ_W'(REFL_ONE)) begin
                r_refl <= REFL_ONE;
            end else begin
                r_refl <= kr[15:0];
            end
        end
    end

    // skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (!i_stall) begin
                r_sv <= 1'b0;
            end
        end else if (r_v8 && i_stall) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sv) begin
            r_srefl <= r_refl;
            r_stir  <= r_tir8;
        end
    end

    assign o_valid          = r_sv || r_v8;
    assign o_reflectance    = r_sv ? r_srefl : r_refl;
    assign o_total_internal = r_sv ? r_stir : r_tir8;

endmodule

// ===== rtl/fresr_checker.sv =====
// ----------------------------------------------------------------------------
// fresr_checker
// Port-level checks on the Fresnel reflectance block.
// ----------------------------------------------------------------------------
module fresr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_reflectance,
    input logic        o_total_internal
);
    import fresr_pkg::*;

    a_tir_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_total_internal |-> o_reflectance == REFL_ONE)
        else $error("total internal reflection without full reflectance");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_reflectance <= REFL_ONE)
        else $error("reflectance above one");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_reflectance)
            && $stable(o_total_internal))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind fresnel_reflectance_top fresr_checker u_fresr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_reflectance    (o_reflectance),
    .o_total_internal (o_total_internal)
);

// ===== verif/fresnel_reflectance_checker.sv =====
// ----------------------------------------------------------------------------
// fresnel_reflectance_checker
// Watches both request channels of the reflectance pipeline, computes the
// expected reflectance and flag for every accepted input request, and compares
// them in order with the accepted output requests.
// ----------------------------------------------------------------------------
module fresnel_reflectance_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [15:0] i_incident_x,
    input  logic signed [15:0] i_incident_y,
    input  logic signed [15:0] i_incident_z,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic        [15:0] i_refractive_index,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic        [15:0] i_reflectance,
    input  logic               i_total_internal,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic [15:0] refl;
        logic        tir;
    } t_refl_result;

    t_refl_result refl_queue[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] coeff_q16(input longint num, input longint den);
        logic [63:0] a;
        logic [63:0] r;
        a = (num < 0) ? -num : num;
        if (den <= 0) return 64'd65536;
        r = ((a << 16) + (den >> 1)) / den;
        return (r > 64'd65536) ? 64'd65536 : r;
    endfunction

    function automatic t_refl_result fresnel_of(
        input logic signed [15:0] ix, iy, iz, nx, ny, nz,
        input logic [15:0] idx);
        longint dot, cosa, sint, cost, etai, etat, n;
        logic [63:0] sinv, rs, rp, kr;
        t_refl_result r;
        dot = longint'(ix) * nx + longint'(iy) * ny + longint'(iz) * nz;
        if (dot > (64'sd1 << 28)) dot = 64'sd1 << 28;
        if (dot < -(64'sd1 << 28)) dot = -(64'sd1 << 28);
        n = (idx == 0) ? 1 : idx;
        cosa = dot < 0 ? -dot : dot;
        sinv = int_sqrt((64'd1 << 56) - cosa * cosa);
        if (dot > 0) begin
            etai = n;
            etat = 4096;
            sint = (n * sinv) >> 12;
        end else begin
            etai = 4096;
            etat = n;
            sint = (sinv << 12) / n;
        end
        if (sint >= (64'sd1 << 28)) begin
            r.refl = 16'h8000;
            r.tir = 1'b1;
            return r;
        end
        cost = int_sqrt((64'd1 << 56) - sint * sint);
        rs = coeff_q16(etat * cosa - etai * cost, etat * cosa + etai * cost);
        rp = coeff_q16(etai * cosa - etat * cost, etai * cosa + etat * cost);
        kr = (rs * rs + rp * rp + (64'd1 << 17)) >> 18;
        if (kr > 32768) kr = 32768;
        r.refl = kr[15:0];
        r.tir = 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_refl_result exp_r;
        if (!i_rst_n) begin
            o_errors <= 0;
            refl_queue.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                refl_queue.push_back(fresnel_of(i_incident_x, i_incident_y, i_incident_z,
                    i_normal_x, i_normal_y, i_normal_z, i_refractive_index));
            if (i_out_valid && !i_out_stall) begin
                if (refl_queue.size() == 0) begin
                    $display("%0t: unexpected result refl=%0d tir=%0b", $time,
                        i_reflectance, i_total_internal);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = refl_queue.pop_front();
                    if (exp_r.refl !== i_reflectance || exp_r.tir !== i_total_internal) begin
                        $display("%0t: mismatch expected refl=%0d tir=%0b actual refl=%0d tir=%0b",
                            $time, exp_r.refl, exp_r.tir, i_reflectance, i_total_internal);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= refl_queue.size();
    end

endmodule

// ===== verif/tb_fresnel_reflectance_top.sv =====
// ----------------------------------------------------------------------------
// tb_fresnel_reflectance_top
// Drives directed and random shading requests into the reflectance pipeline
// with random idling on both sides and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_fresnel_reflectance_top;

    localparam int LATENCY = 112;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_REQUESTS = 1600;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_incident_x = '0;
    logic signed [15:0] i_incident_y = '0;
    logic signed [15:0] i_incident_z = '0;
    logic signed [15:0] i_normal_x = '0;
    logic signed [15:0] i_normal_y = '0;
    logic signed [15:0] i_normal_z = '0;
    logic        [15:0] i_refractive_index = 16'd4096;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic        [15:0] o_reflectance;
    logic               o_total_internal;
    int                 errors;
    int                 pending;
    int                 idle_cycles = 0;
    int                 stall_left = 0;
    bit                 calm = 1'b0;
    bit                 done = 1'b0;

    always #4 i_clk = ~i_clk;

    fresnel_reflectance_top dut (.*);

    fresnel_reflectance_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_incident_x(i_incident_x), .i_incident_y(i_incident_y),
        .i_incident_z(i_incident_z), .i_normal_x(i_normal_x),
        .i_normal_y(i_normal_y), .i_normal_z(i_normal_z),
        .i_refractive_index(i_refractive_index),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_reflectance(o_reflectance), .i_total_internal(o_total_internal),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stalls in random bursts
    always @(negedge i_clk) begin
        if (calm || done) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) i_stall <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(1, 16);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'(signed'($urandom_range(0, 32768)) - 16384);
            1: return 16'($urandom);
            2: return 16'sd16384;
            3: return -16'sd16384;
            default: return 16'(signed'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic send(input logic signed [15:0] ix, iy, iz, nx, ny, nz,
                        input logic [15:0] idx);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_incident_x <= ix; i_incident_y <= iy; i_incident_z <= iz;
        i_normal_x <= nx; i_normal_y <= ny; i_normal_z <= nz;
        i_refractive_index <= idx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_unit(input int k);
        logic signed [15:0] ix, iy, iz, nx, ny, nz;
        logic [15:0] idx;
        ix = 16'(signed'($urandom_range(0, 32768)) - 16384);
        iy = 16'(signed'($urandom_range(0, 32768)) - 16384);
        iz = 16'(signed'($urandom_range(0, 32768)) - 16384);
        nx = rand_comp(); ny = rand_comp(); nz = rand_comp();
        case ($urandom_range(0, 3))
            0: idx = 16'($urandom);
            1: idx = 16'($urandom_range(4096, 8192));
            2: idx = 16'($urandom_range(0, 4096));
            default: idx = 16'($urandom_range(5000, 7000));
        endcase
        if (k % 5 == 0) begin
            ix = 16'($urandom); iy = 16'($urandom); iz = 16'($urandom);
        end
        send(ix, iy, iz, nx, ny, nz, idx);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // normal incidence entering and leaving, grazing, index extremes
        send(-16'sd16384, 0, 0, 16'sd16384, 0, 0, 16'd6144);
        send(16'sd16384, 0, 0, 16'sd16384, 0, 0, 16'd6144);
        send(0, 16'sd16384, 0, 16'sd16384, 0, 0, 16'd6144);
        send(0, 16'sd16384, 0, 16'sd16384, 0, 0, 16'd4096);
        send(-16'sd11585, 16'sd11585, 0, 16'sd16384, 0, 0, 16'd0);
        send(-16'sd11585, 16'sd11585, 0, 16'sd16384, 0, 0, 16'd1);
        send(-16'sd11585, 16'sd11585, 0, 16'sd16384, 0, 0, 16'hFFFF);
        send(16'sd11585, 16'sd11585, 0, 16'sd16384, 0, 0, 16'd6144);
        send(16'sd11585, 16'sd11585, 0, 16'sd16384, 0, 0, 16'hFFFF);
        send(16'sd14000, 16'sd8000, 0, 16'sd16384, 0, 0, 16'd6144);
        send(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd6144);
        send(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd6144);
        send(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd6144);
        send(0, 0, 0, 0, 0, 0, 16'd5000);
        send(16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'd4096);
        send(-16'sd1, 0, 0, 16'sd1, 0, 0, 16'd4097);
        i_valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            if (k == RANDOM_REQUESTS - 200) calm = 1'b1;
            send_unit(k);
        end
        i_valid <= 1'b0;
        done = 1'b1;
        wait (pending == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
